[hdl/ps2hp_pkg.sv]
// ----------------------------------------------------------------------------
// ps2hp_pkg
// Shared types, codes and helpers for the PS/2 host port with receive FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2hp_pkg;

    // request codes carried in s_tuser
    localparam logic [1:0] REQ_CLOCK = 2'd0;
    localparam logic [1:0] REQ_SEND  = 2'd1;
    localparam logic [1:0] REQ_POP   = 2'd2;

    // link mode codes carried in m_tuser
    localparam logic [1:0] LINK_RX  = 2'd0;
    localparam logic [1:0] LINK_TX  = 2'd1;
    localparam logic [1:0] LINK_ERR = 2'd2;

    // start + 8 data + parity + stop
    localparam logic [3:0] FRAME_BITS = 4'd11;

    typedef enum logic [2:0] {
        MODE_RX  = 3'b001,
        MODE_TX  = 3'b010,
        MODE_ERR = 3'b100
    } mode_t;

    // framing engine to FIFO and output stage
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       got;
        logic       drive_low;
        logic [1:0] link_mode;
    } frame_out_t;

    // FIFO command for one transfer
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       flush;
        logic [7:0] push_byte;
    } fifo_cmd_t;

    // bit that gives the byte plus itself odd weight
    function automatic logic odd_parity(input logic [7:0] v);
        odd_parity = ~(^v);
    endfunction

endpackage

`default_nettype wire

[hdl/ps2hp_frame.sv]
// ----------------------------------------------------------------------------
// ps2hp_frame
// Receive/transmit framing engine: start, data, parity, stop and ack bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2hp_frame (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic [1:0]            req_type,
    input  wire logic                  data_line,
    input  wire logic [7:0]            send_byte,
    output ps2hp_pkg::frame_out_t      status
);

    ps2hp_pkg::mode_t mode_reg, mode_next;
    logic [3:0] bits_left_reg, bits_left_next;
    logic [7:0] shift_reg, shift_next;
    logic       parity_hold_reg, parity_hold_next;
    logic       drive_low_reg, drive_low_next;
    logic       push;
    logic       got;
    logic       bad;

    always_comb
    begin
        mode_next        = mode_reg;
        bits_left_next   = bits_left_reg;
        shift_next       = shift_reg;
        parity_hold_next = parity_hold_reg;
        drive_low_next   = drive_low_reg;
        push             = 1'b0;
        got              = 1'b0;
        bad              = 1'b0;

        if (req_type == ps2hp_pkg::REQ_SEND)
        begin
            shift_next     = send_byte;
            drive_low_next = 1'b1;
            mode_next      = ps2hp_pkg::MODE_TX;
            bits_left_next = ps2hp_pkg::FRAME_BITS;
        end
        else if (req_type == ps2hp_pkg::REQ_CLOCK)
        begin
            unique case (mode_reg)
                ps2hp_pkg::MODE_RX:
                begin
                    bad = (bits_left_reg == ps2hp_pkg::FRAME_BITS && data_line)
                       || (bits_left_reg == 4'd2
                           && ps2hp_pkg::odd_parity(shift_reg) != data_line)
                       || (bits_left_reg == 4'd1 && !data_line);
                    if (bits_left_reg < ps2hp_pkg::FRAME_BITS && bits_left_reg > 4'd2)
                        shift_next = {data_line, shift_reg[7:1]};
                    if (bad)
                        mode_next = ps2hp_pkg::MODE_ERR;
                    else if (bits_left_reg <= 4'd1)
                    begin
                        push           = 1'b1;
                        got            = 1'b1;
                        bits_left_next = ps2hp_pkg::FRAME_BITS;
                    end
                    else
                        bits_left_next = bits_left_reg - 4'd1;
                end
                ps2hp_pkg::MODE_TX:
                begin
                    if (bits_left_reg == ps2hp_pkg::FRAME_BITS)
                        parity_hold_next = ps2hp_pkg::odd_parity(shift_reg);
                    if (bits_left_reg <= ps2hp_pkg::FRAME_BITS && bits_left_reg > 4'd3)
                    begin
                        drive_low_next = ~shift_reg[0];
                        shift_next     = {1'b0, shift_reg[7:1]};
                    end
                    if (bits_left_reg == 4'd3)
                        drive_low_next = ~parity_hold_reg;
                    if (bits_left_reg == 4'd2)
                        drive_low_next = 1'b0;
                    // device must pull data low to acknowledge
                    if (bits_left_reg == 4'd1 && data_line)
                        mode_next = ps2hp_pkg::MODE_ERR;
                    else if (bits_left_reg <= 4'd1)
                    begin
                        mode_next      = ps2hp_pkg::MODE_RX;
                        bits_left_next = ps2hp_pkg::FRAME_BITS;
                    end
                    else
                        bits_left_next = bits_left_reg - 4'd1;
                end
                default:
                begin
                    // error mode: clock cycles are ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= ps2hp_pkg::MODE_RX;
            bits_left_reg   <= ps2hp_pkg::FRAME_BITS;
            shift_reg       <= 8'd0;
            parity_hold_reg <= 1'b0;
            drive_low_reg   <= 1'b0;
        end
        else if (en)
        begin
            mode_reg        <= mode_next;
            bits_left_reg   <= bits_left_next;
            shift_reg       <= shift_next;
            parity_hold_reg <= parity_hold_next;
            drive_low_reg   <= drive_low_next;
        end
    end

    always_comb
    begin
        status.push      = push;
        status.push_byte = shift_reg;
        status.got       = got;
        status.drive_low = drive_low_next;
        unique case (mode_next)
            ps2hp_pkg::MODE_TX:  status.link_mode = ps2hp_pkg::LINK_TX;
            ps2hp_pkg::MODE_ERR: status.link_mode = ps2hp_pkg::LINK_ERR;
            default:             status.link_mode = ps2hp_pkg::LINK_RX;
        endcase
    end

endmodule

`default_nettype wire

[hdl/ps2hp_fifo.sv]
// ----------------------------------------------------------------------------
// ps2hp_fifo
// Receive FIFO: one synchronous memory, pointers, count, flush on send.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2hp_fifo #(
    parameter int DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire ps2hp_pkg::fifo_cmd_t  cmd,
    output logic                       pop_ok,
    output logic [7:0]                 rd_data,
    output logic [4:0]                 level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push_ok;
    logic [CW+4:0] count_ext;

    assign push_ok = cmd.push && (count_reg < CW'(DEPTH));
    assign pop_ok  = cmd.pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (cmd.flush)
        begin
            rd_ptr_next = wr_ptr_reg;
            count_next  = '0;
        end
        else if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    assign count_ext = {5'd0, count_next};
    assign level     = count_ext[4:0];

    // push and pop never share a transfer, so no same-entry collision
    always_ff @(posedge clk)
    begin
        if (en && push_ok)
            mem[wr_ptr_reg] <= cmd.push_byte;
        if (en && pop_ok)
            rd_data <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (en)
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/ps2_host_port_with_rx_fifo.sv]
// ----------------------------------------------------------------------------
// ps2_host_port_with_rx_fifo
// PS/2 host port: frame receive/transmit with a receive byte FIFO.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns exactly one result for each, in the
// cycle after the input transfer; the FIFO memory read port and the result
// fields are registered on the transfer. A clock request stands for a whole
// device clock period with the data level sampled at its falling edge. Good
// received bytes go into a FIFO_DEPTH entry FIFO (a byte arriving when it is
// full is dropped); a send request flushes the FIFO and starts a transmit
// frame. Framing errors are sticky until the next send. The input stalls
// only while a result waits and the output is not ready.
`default_nettype none

module ps2_host_port_with_rx_fifo #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // data_line, send_byte[7:0], zero pad
    input  wire logic [1:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0] m_tdata,        // popped_byte[7:0], popped_valid,
                                        // fifo_level[4:0], drive_data_low,
                                        // byte_received
    output logic [1:0]       m_tuser    // link_mode
);

    ps2hp_pkg::frame_out_t status;
    ps2hp_pkg::fifo_cmd_t  cmd;
    logic       xfer_in;
    logic       pop_ok;
    logic [7:0] rd_data;
    logic [4:0] level;

    logic       m_tvalid_reg;
    logic       pvalid_reg;
    logic [4:0] level_reg;
    logic       drive_reg;
    logic       got_reg;
    logic [1:0] link_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign xfer_in  = s_tvalid && s_tready;

    ps2hp_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (xfer_in),
        .req_type  (s_tuser),
        .data_line (s_tdata[0]),
        .send_byte (s_tdata[8:1]),
        .status    (status)
    );

    always_comb
    begin
        cmd.push      = status.push;
        cmd.push_byte = status.push_byte;
        cmd.pop       = (s_tuser == ps2hp_pkg::REQ_POP);
        cmd.flush     = (s_tuser == ps2hp_pkg::REQ_SEND);
    end

    ps2hp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (xfer_in),
        .cmd     (cmd),
        .pop_ok  (pop_ok),
        .rd_data (rd_data),
        .level   (level)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (xfer_in)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (xfer_in)
        begin
            pvalid_reg <= pop_ok;
            level_reg  <= level;
            drive_reg  <= status.drive_low;
            got_reg    <= status.got;
            link_reg   <= status.link_mode;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {got_reg, drive_reg, level_reg, pvalid_reg,
                       (pvalid_reg ? rd_data : 8'd0)};
    assign m_tuser  = link_reg;

    // the input side is always ready when no result is pending
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // a send shows the start bit driven and transmit mode in its result
    a_send_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == ps2hp_pkg::REQ_SEND)
        |=> (m_tvalid && m_tdata[14] && m_tuser == ps2hp_pkg::LINK_TX))
        else $error("send result wrong");

    // a completed frame is only reported while receiving
    a_got_in_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[15]) |-> (m_tuser == ps2hp_pkg::LINK_RX))
        else $error("frame done outside receive mode");

    // a pop result never also reports a received frame
    a_pop_no_got: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[8]) |-> !m_tdata[15])
        else $error("pop and received frame in one result");

endmodule

`default_nettype wire
